// ===== src/dqkc_pkg.sv =====
// ---------------------------------------------------------------------------
// dqkc_pkg: shared types for the deque with keyed cancel
// Transaction structs, operation codes and the command and status bundles
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package dqkc_pkg;

   // Fixed widths of the transaction fields.
   localparam int FIELD_BITS = 32;
   localparam int OCC_BITS   = 8;

   // Operation codes carried in a request.
   typedef enum logic [1:0] {
      FUNC_PUSH_BACK  = 2'd0,
      FUNC_PUSH_FRONT = 2'd1,
      FUNC_POP_FRONT  = 2'd2,
      FUNC_CANCEL     = 2'd3
   } func_type;

   // Request transaction.
   typedef struct packed {
      func_type                func;
      logic [FIELD_BITS-1:0]   key;
      logic [FIELD_BITS-1:0]   payload;
   } req_item_type;

   // Response transaction.
   typedef struct packed {
      logic                    ok;
      logic [FIELD_BITS-1:0]   out_key;
      logic [FIELD_BITS-1:0]   out_payload;
      logic [OCC_BITS-1:0]     occupancy;
   } rsp_item_type;

   // Where a storage write lands.
   typedef enum logic [1:0] {
      WR_TAIL  = 2'd0,
      WR_FRONT = 2'd1,
      WR_SHIFT = 2'd2
   } wr_sel_type;

   // Which logical position a storage read fetches.
   typedef enum logic {
      RD_FIRST = 1'b0,
      RD_NEXT  = 1'b1
   } rd_sel_type;

   // Source of the entry returned in a response.
   typedef enum logic [1:0] {
      RSP_NONE = 2'd0,
      RSP_REQ  = 2'd1,
      RSP_RAM  = 2'd2,
      RSP_HOLD = 2'd3
   } rsp_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_req;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        idx_clr;
      logic        idx_inc;
      logic        head_inc;
      logic        head_dec;
      logic        count_inc;
      logic        count_dec;
      logic        hold_load;
      logic        rsp_fire;
      rsp_src_type rsp_src;
   } dqkc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type    func;
      logic        full;
      logic        empty;
      logic        key_match;
      logic        scan_last;
   } dqkc_stat_type;

endpackage

// ===== src/dqkc_ram.sv =====
// ---------------------------------------------------------------------------
// dqkc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dqkc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dqkc_dp.sv =====
// ---------------------------------------------------------------------------
// dqkc_dp: datapath of the deque with keyed cancel
// Holds the circular entry store, the head pointer, the entry count, the
// scan index and the response register, and acts on controller commands.
// ---------------------------------------------------------------------------
module dqkc_dp #(
   parameter int QUEUE_DEPTH  = 128,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dqkc_pkg::req_item_type req_item,
   input  dqkc_pkg::dqkc_cmd_type cmd,
   output dqkc_pkg::dqkc_stat_type stat,
   output logic                   rsp_valid,
   output dqkc_pkg::rsp_item_type rsp_item
);

   import dqkc_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
   localparam int PW = (PAYLOAD_BITS < FIELD_BITS) ? PAYLOAD_BITS : FIELD_BITS;
   localparam int EW = KW + PW;
   localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);
   localparam logic [AW-1:0] LAST_PTR  = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   // Latched request.
   func_type       func_ff;
   logic [KW-1:0]  key_ff;
   logic [PW-1:0]  pay_ff;

   // Queue control state.
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;

   // Entry found by a cancel, held while the gap closes.
   logic [KW-1:0]  hold_key_ff;
   logic [PW-1:0]  hold_pay_ff;

   // Response register.
   logic           rsp_valid_ff;
   rsp_item_type   rsp_ff, rsp_in;

   // Storage interface.
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [EW-1:0]  wr_data, rd_data;
   logic [KW-1:0]  ram_key;
   logic [PW-1:0]  ram_pay;

   logic [AW-1:0]  head_prev, head_next;
   logic [CW-1:0]  idx_next, idx_prev, rd_off;

   // Physical address of a logical position counted from the head.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW + 1)'(off);
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[AW-1:0];
   endfunction

   // Pointer and index neighbors.
   assign head_prev = (head_ff == '0) ? LAST_PTR : head_ff - 1'b1;
   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign idx_next  = idx_ff + 1'b1;
   assign idx_prev  = idx_ff - 1'b1;

   // Read address: the head, or the position after the scan index.
   assign rd_off  = (cmd.rd_sel == RD_NEXT) ? idx_next : '0;
   assign rd_addr = wrap_add(head_ff, rd_off);

   assign ram_key = rd_data[EW-1:PW];
   assign ram_pay = rd_data[PW-1:0];

   // Write address and data for appends, urgent inserts and gap closing.
   always_comb begin
      wr_data = {key_ff, pay_ff};
      case (cmd.wr_sel)
         WR_TAIL:  wr_addr = wrap_add(head_ff, count_ff);
         WR_FRONT: wr_addr = head_prev;
         WR_SHIFT: begin
            wr_addr = wrap_add(head_ff, idx_prev);
            wr_data = rd_data;
         end
         default:  wr_addr = wrap_add(head_ff, count_ff);
      endcase
   end

   dqkc_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next values of the queue control state.
   always_comb begin
      head_in = head_ff;
      if (cmd.head_inc) begin
         head_in = head_next;
      end else if (cmd.head_dec) begin
         head_in = head_prev;
      end

      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
   end

   // Response contents; a failed operation returns a zero entry.
   always_comb begin
      rsp_in           = rsp_ff;
      rsp_in.ok        = (cmd.rsp_src != RSP_NONE);
      rsp_in.occupancy = OCC_BITS'(count_in);
      case (cmd.rsp_src)
         RSP_REQ: begin
            rsp_in.out_key     = FIELD_BITS'(key_ff);
            rsp_in.out_payload = FIELD_BITS'(pay_ff);
         end
         RSP_RAM: begin
            rsp_in.out_key     = FIELD_BITS'(ram_key);
            rsp_in.out_payload = FIELD_BITS'(ram_pay);
         end
         RSP_HOLD: begin
            rsp_in.out_key     = FIELD_BITS'(hold_key_ff);
            rsp_in.out_payload = FIELD_BITS'(hold_pay_ff);
         end
         default: begin
            rsp_in.out_key     = '0;
            rsp_in.out_payload = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.rsp_fire;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_item.func;
         key_ff  <= KW'(req_item.key);
         pay_ff  <= PW'(req_item.payload);
      end
      if (cmd.hold_load) begin
         hold_key_ff <= ram_key;
         hold_pay_ff <= ram_pay;
      end
      if (cmd.rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Status for the controller.
   always_comb begin
      stat.func      = func_ff;
      stat.full      = (count_ff == DEPTH_CNT);
      stat.empty     = (count_ff == '0);
      stat.key_match = (ram_key == key_ff);
      stat.scan_last = (idx_next == count_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The entry count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above capacity");

   // A failed operation returns an all-zero entry.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff.out_key == '0 && rsp_ff.out_payload == '0)
      else $error("failed operation returned a nonzero entry");

   // A successful push grows the queue by one entry.
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok &&
      (func_ff == FUNC_PUSH_BACK || func_ff == FUNC_PUSH_FRONT)
      |-> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not add exactly one entry");

   // A successful pop or cancel shrinks the queue by one entry.
   a_remove_shrink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok &&
      (func_ff == FUNC_POP_FRONT || func_ff == FUNC_CANCEL)
      |-> count_ff == $past(count_ff) - 1'b1)
      else $error("removal did not take exactly one entry");

endmodule

// ===== src/dqkc_ctrl.sv =====
// ---------------------------------------------------------------------------
// dqkc_ctrl: controller of the deque with keyed cancel
// Sequences each transaction: decode, head read for a pop, key scan and
// gap closing for a cancel, and the single response strobe.
// ---------------------------------------------------------------------------
module dqkc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  dqkc_pkg::dqkc_stat_type stat,
   output dqkc_pkg::dqkc_cmd_type  cmd
);

   import dqkc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_DECODE = 3'd1,
      ST_POP    = 3'd2,
      ST_SCAN   = 3'd3,
      ST_SHIFT  = 3'd4
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in     = ST_IDLE;
            cmd.rsp_fire = 1'b1;
            cmd.rsp_src  = RSP_NONE;
            case (stat.func)
               FUNC_PUSH_BACK: begin
                  if (!stat.full) begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_TAIL;
                     cmd.count_inc = 1'b1;
                     cmd.rsp_src   = RSP_REQ;
                  end
               end
               FUNC_PUSH_FRONT: begin
                  if (!stat.full) begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_FRONT;
                     cmd.head_dec  = 1'b1;
                     cmd.count_inc = 1'b1;
                     cmd.rsp_src   = RSP_REQ;
                  end
               end
               FUNC_POP_FRONT: begin
                  if (!stat.empty) begin
                     cmd.rsp_fire = 1'b0;
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = RD_FIRST;
                     state_in     = ST_POP;
                  end
               end
               FUNC_CANCEL: begin
                  if (!stat.empty) begin
                     cmd.rsp_fire = 1'b0;
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = RD_FIRST;
                     cmd.idx_clr  = 1'b1;
                     state_in     = ST_SCAN;
                  end
               end
               default: begin
                  cmd.rsp_src = RSP_NONE;
               end
            endcase
         end

         // Head entry is on the read port: retire it.
         ST_POP: begin
            cmd.head_inc  = 1'b1;
            cmd.count_dec = 1'b1;
            cmd.rsp_fire  = 1'b1;
            cmd.rsp_src   = RSP_RAM;
            state_in      = ST_IDLE;
         end

         // Compare one entry per cycle while the next one is read.
         ST_SCAN: begin
            if (stat.key_match) begin
               if (stat.scan_last) begin
                  cmd.count_dec = 1'b1;
                  cmd.rsp_fire  = 1'b1;
                  cmd.rsp_src   = RSP_RAM;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.hold_load = 1'b1;
                  cmd.rd_en     = 1'b1;
                  cmd.rd_sel    = RD_NEXT;
                  cmd.idx_inc   = 1'b1;
                  state_in      = ST_SHIFT;
               end
            end else if (stat.scan_last) begin
               cmd.rsp_fire = 1'b1;
               cmd.rsp_src  = RSP_NONE;
               state_in     = ST_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_NEXT;
               cmd.idx_inc = 1'b1;
            end
         end

         // Move each later entry one place toward the head.
         ST_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            if (stat.scan_last) begin
               cmd.count_dec = 1'b1;
               cmd.rsp_fire  = 1'b1;
               cmd.rsp_src   = RSP_HOLD;
               state_in      = ST_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_NEXT;
               cmd.idx_inc = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   // A response ends the transaction and frees the block.
   a_rsp_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire |=> state_ff == ST_IDLE && !busy_ff)
      else $error("response issued without returning to idle");

   // The count never grows and shrinks in one cycle.
   a_count_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.count_inc, cmd.count_dec, cmd.head_inc && cmd.head_dec}))
      else $error("conflicting count or head commands");

   // Gap closing always starts from a captured match.
   a_shift_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> $past(cmd.hold_load) || $past(state_ff) == ST_SHIFT)
      else $error("gap closing entered without a captured entry");

endmodule

// ===== src/deque_with_keyed_cancel.sv =====
// ---------------------------------------------------------------------------
// deque_with_keyed_cancel: bounded deque with urgent insert and keyed cancel
// Entries of key and payload kept in order in a circular store; push back,
// push front, pop front and cancel of the first entry with a given key.
// ---------------------------------------------------------------------------
// One transaction at a time: a request is taken when start is high and busy
// is low, and exactly one response follows as a one-cycle rsp_valid strobe.
// The response cannot be held off; busy is already low in its cycle, so the
// next request may be taken at the edge that ends it. The entries live in one
// single-port-read RAM: a pop reads the head entry before it retires it, and a
// cancel reads one entry per cycle to find the key, then rewrites every entry
// behind it one place toward the head, one per cycle. A failed operation
// returns ok low with a zero entry. Keys and payloads are kept to KEY_BITS and
// PAYLOAD_BITS bits, at most 32 each; occupancy gives the low 8 bits of the
// count after the operation. Storage needs no clearing after reset.
// ---------------------------------------------------------------------------
module deque_with_keyed_cancel #(
   parameter int QUEUE_DEPTH  = 128,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dqkc_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output dqkc_pkg::rsp_item_type rsp_item
);

   import dqkc_pkg::*;

   dqkc_cmd_type  cmd;
   dqkc_stat_type stat;

   // Sequencer.
   dqkc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Storage, pointers and response register.
   dqkc_dp #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
